// File: rtl/slla_pkg.sv
// shared constants and types for the sticky least-loaded assignment block
`timescale 1ns / 1ps

package slla_pkg;

    localparam int SLLA_MAX_SERVERS = 8;
    localparam int SLLA_MAX_CLIENTS = 64;
    localparam int SLLA_KEY_BITS    = 32;

    localparam int KEY_IN_W   = 32;
    localparam int KEY_EXT_W  = 64;
    localparam int IDX_OUT_W  = 3;
    localparam int MASK_W     = 8;
    localparam int MASK_IDX_W = 3;
    localparam int LOAD_W     = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [LOAD_W-1:0] LOAD_MAX = 7'd127;

    typedef enum logic [0:0] {
        REG_ACTIVE_MASK = 1'b0
    } t_reg_idx;

endpackage

// File: rtl/slla_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface slla_req_if import slla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KEY_IN_W-1:0] client_key;

    modport source (output valid, output client_key, input ready);
    modport sink   (input valid, input client_key, output ready);
endinterface

interface slla_rsp_if import slla_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] server_index;
    logic                 server_valid;
    logic                 already_assigned;
    logic                 table_full;

    modport source (output valid, output server_index, output server_valid,
                    output already_assigned, output table_full, input ready);
    modport sink   (input valid, input server_index, input server_valid,
                    input already_assigned, input table_full, output ready);
endinterface

// File: rtl/slla_cfg.sv
// apb register file holding the active server mask
`timescale 1ns / 1ps

module slla_cfg import slla_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [MASK_W-1:0]     o_active_mask
);

    logic [MASK_W-1:0] r_mask;
    logic              w_hit;

    assign w_hit  = (paddr[APB_ADDR_W-1] == REG_ACTIVE_MASK);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (psel && penable && pwrite && w_hit) begin
            r_mask <= pwdata[MASK_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = {{(APB_DATA_W-MASK_W){1'b0}}, r_mask};
        end
    end

    assign o_active_mask = r_mask;

endmodule

// File: rtl/slla_entry_mem.sv
// client assignment table: key and server per entry, registered read
`timescale 1ns / 1ps

module slla_entry_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 35
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/slla_load_mem.sv
// per-server client counts, registered read, unwritten entries read as zero
`timescale 1ns / 1ps

module slla_load_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_ok;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok    <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_we) begin
                r_ok[i_waddr] <= 1'b1;
            end
            r_rd_ok <= r_ok[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

// File: rtl/sticky_least_loaded_assign.sv
// top level: sequencer that scans the assignment table and the server counts
// steps: the request is accepted, the table is scanned for its key, and for a new key
// the server counts are scanned, ending in the decide, and then the result is registered
// a known key stops the table scan at its entry; one word at a time, a held result stalls
// reset: synchronous active low; clears the mask, the fill count and the count valid bits
// no clearing pass is needed since the table fills in order from entry zero
`timescale 1ns / 1ps

module sticky_least_loaded_assign import slla_pkg::*; #(
    parameter int MAX_SERVERS = SLLA_MAX_SERVERS,
    parameter int MAX_CLIENTS = SLLA_MAX_CLIENTS,
    parameter int KEY_BITS    = SLLA_KEY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    slla_req_if.sink              i_req,
    slla_rsp_if.source            o_rsp
);

    localparam int SRV_W  = $clog2(MAX_SERVERS);
    localparam int SRV_CW = $clog2(MAX_SERVERS + 1);
    localparam int CLI_W  = $clog2(MAX_CLIENTS);
    localparam int CLI_CW = $clog2(MAX_CLIENTS + 1);
    localparam int ENT_W  = KEY_BITS + SRV_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [MASK_W-1:0]    w_mask;
    logic [KEY_EXT_W-1:0] w_key_ext;

    logic [CLI_CW-1:0]    r_rd_idx, n_rd_idx;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [CLI_CW-1:0]    r_fill, n_fill;
    logic [SRV_CW-1:0]    r_ld_idx, n_ld_idx;
    logic                 r_ld_cmp_vld, n_ld_cmp_vld;
    logic                 r_found, n_found;
    logic                 r_out_vld, n_out_vld;

    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [SRV_W-1:0]     r_ld_cmp_idx, n_ld_cmp_idx;
    logic [SRV_W-1:0]     r_best, n_best;
    logic [LOAD_W-1:0]    r_best_load, n_best_load;
    logic [IDX_OUT_W-1:0] r_res_idx, n_res_idx;
    logic                 r_res_sv, n_res_sv;
    logic                 r_res_aa, n_res_aa;
    logic                 r_res_tf, n_res_tf;
    logic [IDX_OUT_W-1:0] r_out_idx, n_out_idx;
    logic                 r_out_sv, n_out_sv;
    logic                 r_out_aa, n_out_aa;
    logic                 r_out_tf, n_out_tf;

    logic                 w_ent_we;
    logic [ENT_W-1:0]     w_ent_rdata;
    logic                 w_ld_we;
    logic [LOAD_W-1:0]    w_ld_wdata;
    logic [LOAD_W-1:0]    w_ld_rdata;
    logic                 w_rd_issue;
    logic                 w_ld_issue;
    logic                 w_match;
    logic [31:0]          w_ent_srv_ext;
    logic [31:0]          w_best_ext;
    logic [31:0]          w_cmp_ext;
    logic                 w_cmp_active;

    slla_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_active_mask (w_mask)
    );

    slla_entry_mem #(
        .DEPTH (MAX_CLIENTS),
        .WIDTH (ENT_W)
    ) u_entry_mem (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (r_fill[CLI_W-1:0]),
        .i_wdata ({r_key, r_best}),
        .i_raddr (r_rd_idx[CLI_W-1:0]),
        .o_rdata (w_ent_rdata)
    );

    slla_load_mem #(
        .DEPTH (MAX_SERVERS),
        .WIDTH (LOAD_W)
    ) u_load_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_ld_we),
        .i_waddr (r_best),
        .i_wdata (w_ld_wdata),
        .i_raddr (r_ld_idx[SRV_W-1:0]),
        .o_rdata (w_ld_rdata)
    );

    assign w_key_ext     = {{(KEY_EXT_W-KEY_IN_W){1'b0}}, i_req.client_key};
    assign w_rd_issue    = (r_rd_idx < r_fill);
    assign w_ld_issue    = (r_ld_idx < SRV_CW'(MAX_SERVERS));
    assign w_match       = r_cmp_vld && (w_ent_rdata[ENT_W-1:SRV_W] == r_key);
    assign w_ent_srv_ext = 32'(w_ent_rdata[SRV_W-1:0]);
    assign w_best_ext    = 32'(r_best);
    assign w_cmp_ext     = 32'(r_ld_cmp_idx);
    assign w_cmp_active  = (w_cmp_ext < 32'(MASK_W)) && w_mask[w_cmp_ext[MASK_IDX_W-1:0]];
    assign w_ld_wdata    = (r_best_load == LOAD_MAX) ? r_best_load : r_best_load + 1'b1;

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.server_index     = r_out_idx;
    assign o_rsp.server_valid     = r_out_sv;
    assign o_rsp.already_assigned = r_out_aa;
    assign o_rsp.table_full       = r_out_tf;

    always_comb begin
        n_state      = r_state;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = r_cmp_vld;
        n_fill       = r_fill;
        n_ld_idx     = r_ld_idx;
        n_ld_cmp_vld = r_ld_cmp_vld;
        n_found      = r_found;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_key        = r_key;
        n_ld_cmp_idx = r_ld_cmp_idx;
        n_best       = r_best;
        n_best_load  = r_best_load;
        n_res_idx    = r_res_idx;
        n_res_sv     = r_res_sv;
        n_res_aa     = r_res_aa;
        n_res_tf     = r_res_tf;
        n_out_idx    = r_out_idx;
        n_out_sv     = r_out_sv;
        n_out_aa     = r_out_aa;
        n_out_tf     = r_out_tf;
        w_ent_we     = 1'b0;
        w_ld_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key     = w_key_ext[KEY_BITS-1:0];
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    n_res_idx = w_ent_srv_ext[IDX_OUT_W-1:0];
                    n_res_sv  = 1'b1;
                    n_res_aa  = 1'b1;
                    n_res_tf  = 1'b0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_DONE;
                end else if (w_rd_issue) begin
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                end else if (r_cmp_vld) begin
                    n_cmp_vld = 1'b0;
                end else begin
                    n_ld_idx     = '0;
                    n_ld_cmp_vld = 1'b0;
                    n_found      = 1'b0;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_ld_cmp_vld && w_cmp_active && (!r_found || w_ld_rdata < r_best_load)) begin
                    n_found     = 1'b1;
                    n_best      = r_ld_cmp_idx;
                    n_best_load = w_ld_rdata;
                end
                if (w_ld_issue) begin
                    n_ld_idx     = r_ld_idx + 1'b1;
                    n_ld_cmp_vld = 1'b1;
                    n_ld_cmp_idx = r_ld_idx[SRV_W-1:0];
                end else if (r_ld_cmp_vld) begin
                    n_ld_cmp_vld = 1'b0;
                end else begin
                    n_state  = S_DONE;
                    n_res_aa = 1'b0;
                    if (!r_found) begin
                        n_res_idx = '0;
                        n_res_sv  = 1'b0;
                        n_res_tf  = 1'b0;
                    end else begin
                        n_res_idx = w_best_ext[IDX_OUT_W-1:0];
                        n_res_sv  = 1'b1;
                        if (r_fill == CLI_CW'(MAX_CLIENTS)) begin
                            n_res_tf = 1'b1;
                        end else begin
                            n_res_tf = 1'b0;
                            w_ent_we = 1'b1;
                            w_ld_we  = 1'b1;
                            n_fill   = r_fill + 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld = 1'b1;
                    n_out_idx = r_res_idx;
                    n_out_sv  = r_res_sv;
                    n_out_aa  = r_res_aa;
                    n_out_tf  = r_res_tf;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_idx     <= '0;
            r_cmp_vld    <= 1'b0;
            r_fill       <= '0;
            r_ld_idx     <= '0;
            r_ld_cmp_vld <= 1'b0;
            r_found      <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_idx     <= n_rd_idx;
            r_cmp_vld    <= n_cmp_vld;
            r_fill       <= n_fill;
            r_ld_idx     <= n_ld_idx;
            r_ld_cmp_vld <= n_ld_cmp_vld;
            r_found      <= n_found;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_ld_cmp_idx <= n_ld_cmp_idx;
        r_best       <= n_best;
        r_best_load  <= n_best_load;
        r_res_idx    <= n_res_idx;
        r_res_sv     <= n_res_sv;
        r_res_aa     <= n_res_aa;
        r_res_tf     <= n_res_tf;
        r_out_idx    <= n_out_idx;
        r_out_sv     <= n_out_sv;
        r_out_aa     <= n_out_aa;
        r_out_tf     <= n_out_tf;
    end

endmodule

// File: dv/tb_sticky_least_loaded_assign.sv
// testbench for the sticky least-loaded assignment block: directed and random requests
`timescale 1ns / 1ps

module tb_sticky_least_loaded_assign;
    import slla_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 2;
    localparam int RAND_PHASES  = 16;
    localparam int PHASE_WORDS  = 114;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_MASK = APB_ADDR_W'(REG_ACTIVE_MASK) << 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED    = ADDR_ACTIVE_MASK + 3'd4;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] server_index;
        logic                 server_valid;
        logic                 already_assigned;
        logic                 table_full;
    } t_assign_word;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    slla_req_if req_if ();
    slla_rsp_if rsp_if ();

    sticky_least_loaded_assign dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // model of the assignment table and server counts
    logic [KEY_IN_W-1:0]  tbl_key    [SLLA_MAX_CLIENTS];
    logic [IDX_OUT_W-1:0] tbl_server [SLLA_MAX_CLIENTS];
    bit                   tbl_used   [SLLA_MAX_CLIENTS];
    logic [LOAD_W-1:0]    srv_load   [SLLA_MAX_SERVERS];
    logic [MASK_W-1:0]    model_mask = '0;

    t_assign_word        expected_assignments[$];
    logic [KEY_IN_W-1:0] key_pool[$];
    int                  errors     = 0;
    int                  burst_left = 0;
    t_rx_mode            rx_mode    = RX_OPEN;
    int                  rx_left    = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("FAIL sticky_least_loaded_assign");
        $finish;
    end

    function automatic t_assign_word predict_assignment(input logic [KEY_IN_W-1:0] key);
        t_assign_word res;
        int           best;
        int           slot;
        res = '0;
        for (int e = 0; e < SLLA_MAX_CLIENTS; e++) begin
            if (tbl_used[e] && tbl_key[e] == key) begin
                res.server_index     = tbl_server[e];
                res.server_valid     = 1'b1;
                res.already_assigned = 1'b1;
                return res;
            end
        end
        // strict compare keeps the lowest index on ties
        best = -1;
        for (int s = 0; s < SLLA_MAX_SERVERS; s++) begin
            if (model_mask[s] && (best < 0 || srv_load[s] < srv_load[best]))
                best = s;
        end
        if (best < 0)
            return res;
        res.server_index = IDX_OUT_W'(best);
        res.server_valid = 1'b1;
        slot = -1;
        for (int e = SLLA_MAX_CLIENTS - 1; e >= 0; e--) begin
            if (!tbl_used[e])
                slot = e;
        end
        if (slot < 0) begin
            res.table_full = 1'b1;
        end else begin
            tbl_used[slot]   = 1'b1;
            tbl_key[slot]    = key;
            tbl_server[slot] = IDX_OUT_W'(best);
            if (srv_load[best] != LOAD_MAX)
                srv_load[best] = srv_load[best] + 1'b1;
        end
        return res;
    endfunction

    task automatic send_key(input logic [KEY_IN_W-1:0] key);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid      <= 1'b1;
        req_if.client_key <= key;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_assignments = {expected_assignments, predict_assignment(key)};
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_assignments.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr[APB_ADDR_W-1:2] == REG_ACTIVE_MASK)
            model_mask = data[MASK_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write a register, then read the mask back
    task automatic write_and_verify(input logic [APB_ADDR_W-1:0] addr,
                                    input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] rd;
        apb_write(addr, data);
        apb_read(ADDR_ACTIVE_MASK, rd);
        if (rd[MASK_W-1:0] !== model_mask) begin
            $display("%0t: mask readback mismatch expected %h actual %h",
                     $time, model_mask, rd[MASK_W-1:0]);
            errors++;
        end
    endtask

    task automatic test_no_active_server();
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'hA5A5_A5A5);
        wait_idle();
    endtask

    task automatic test_register_access();
        write_and_verify(ADDR_ACTIVE_MASK, 32'hFFFF_FF5A);
        write_and_verify(ADDR_UNMAPPED, 32'h0000_0000);
        write_and_verify(ADDR_ACTIVE_MASK, 32'h0000_0000);
    endtask

    task automatic test_least_loaded();
        write_and_verify(ADDR_ACTIVE_MASK, 32'h0000_00FF);
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'h0000_0001);
        send_key(32'h8000_0000);
        send_key(32'h5555_5555);
        send_key(32'hAAAA_AAAA);
        send_key(32'h7FFF_FFFE);
        send_key(32'h1234_5678);
        send_key(32'h0000_0001);
        wait_idle();
        // equal counts on the two active servers
        write_and_verify(ADDR_ACTIVE_MASK, 32'h0000_000C);
        send_key(32'hC0FF_EE00);
        send_key(32'hC0FF_EE01);
        wait_idle();
    endtask

    task automatic test_sticky_inactive();
        write_and_verify(ADDR_ACTIVE_MASK, 32'h0000_0001);
        send_key(32'hFFFF_FFFF);
        send_key(32'h1234_5678);
        wait_idle();
        write_and_verify(ADDR_ACTIVE_MASK, 32'h0000_0000);
        send_key(32'h0000_0000);
        send_key(32'h0000_0002);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [APB_DATA_W-1:0] phase_mask;
        logic [KEY_IN_W-1:0]   key;
        int                    pick;
        for (int p = 0; p < RAND_PHASES; p++) begin
            phase_mask = $urandom;
            case (p)
                0, 4:    phase_mask[MASK_W-1:0] = '1;
                1:       phase_mask[MASK_W-1:0] = 8'h01;
                2:       phase_mask[MASK_W-1:0] = 8'h80;
                3, 9:    phase_mask[MASK_W-1:0] = '0;
                default: ;
            endcase
            wait_idle();
            write_and_verify(ADDR_ACTIVE_MASK, phase_mask);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(0, 99);
                if (key_pool.size() == 0 || pick < 15) begin
                    key = $urandom;
                    key_pool = {key_pool, key};
                end else if (pick < 25) begin
                    // near miss of a known key
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)]
                          ^ (32'h1 << $urandom_range(0, KEY_IN_W - 1));
                end else begin
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end
                send_key(key);
            end
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:     rsp_if.ready <= 1'b1;
            RX_COIN:     rsp_if.ready <= $urandom_range(0, 1);
            RX_PERIODIC: rsp_if.ready <= (rx_left[1:0] == 2'b00);
            default:     rsp_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_assign_word want;
        t_assign_word got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.server_index, rsp_if.server_valid,
                   rsp_if.already_assigned, rsp_if.table_full};
            if (expected_assignments.size() == 0) begin
                $display("%0t: unexpected word expected none actual idx %h vld %b asg %b full %b",
                         $time, got.server_index, got.server_valid,
                         got.already_assigned, got.table_full);
                errors++;
            end else begin
                want = expected_assignments.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected idx %h vld %b asg %b full %b",
                             $time, want.server_index, want.server_valid,
                             want.already_assigned, want.table_full);
                    $display("%0t:          actual   idx %h vld %b asg %b full %b",
                             $time, got.server_index, got.server_valid,
                             got.already_assigned, got.table_full);
                    errors++;
                end
            end
        end
    end

    initial begin
        for (int e = 0; e < SLLA_MAX_CLIENTS; e++)
            tbl_used[e] = 1'b0;
        for (int s = 0; s < SLLA_MAX_SERVERS; s++)
            srv_load[s] = '0;
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_if.valid      <= 1'b0;
        req_if.client_key <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_active_server();
        test_register_access();
        test_least_loaded();
        test_sticky_inactive();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS sticky_least_loaded_assign");
        else
            $display("FAIL sticky_least_loaded_assign");
        $finish;
    end

endmodule

// File: sim.f
rtl/slla_pkg.sv
rtl/slla_if.sv
rtl/slla_cfg.sv
rtl/slla_entry_mem.sv
rtl/slla_load_mem.sv
rtl/sticky_least_loaded_assign.sv
dv/tb_sticky_least_loaded_assign.sv
